// ===== rtl/core/gws_pkg.sv =====
// ----------------------------------------------------------------------------
// gws_pkg
// Shared widths, register indexes, routing mode codes and the result type
// of the gateway selection block.
// ----------------------------------------------------------------------------
package gws_pkg;

    localparam int ADDR_W  = 32;
    localparam int CLASS_W = 4;
    localparam int COUNT_W = 16;
    localparam int FACT_W  = CLASS_W + COUNT_W;
    localparam int IDX_W   = 8;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROUTING_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFERRED_ADDRESS = 1'b1;

    // routing modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLASS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FACTOR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [IDX_W-1:0]  index;
        logic              changed;
        logic              no_gw;
        logic              pref_hit;
    } gws_result_t;

endpackage

// ===== rtl/core/gws_scan.sv =====
// ----------------------------------------------------------------------------
// gws_scan
// Configuration registers, running maxima and candidate tracking for one
// gateway scan; forms the result of a transaction in the same cycle.
// ----------------------------------------------------------------------------
module gws_scan #(
    parameter int MAX_GATEWAYS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [gws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gws_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_fire,
    input  logic [gws_pkg::ADDR_W-1:0]   gateway_address,
    input  logic [gws_pkg::CLASS_W-1:0]  advert_class,
    input  logic [gws_pkg::COUNT_W-1:0]  received_count,
    input  logic                         no_entries,
    input  logic                         last_entry,
    output logic                         res_valid,
    output gws_pkg::gws_result_t         res
);
    import gws_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_GATEWAYS - 1);

    logic [MODE_W-1:0]  mode_reg;
    logic [ADDR_W-1:0]  pref_reg;

    logic [CLASS_W-1:0] best_class_reg, best_class_next, best_class_upd;
    logic [COUNT_W-1:0] best_count_reg, best_count_next, best_count_upd;
    logic [FACT_W-1:0]  best_factor_reg, best_factor_next, best_factor_upd;
    logic [ADDR_W-1:0]  cand_addr_reg, cand_addr_next, cand_addr_upd;
    logic [IDX_W-1:0]   cand_idx_reg, cand_idx_next, cand_idx_upd;
    logic [IDX_W-1:0]   counter_reg, counter_next, counter_upd;
    logic               locked_reg, locked_next, locked_upd;
    logic               full_reg, full_next, full_upd;
    logic [ADDR_W-1:0]  cur_addr_reg, cur_addr_next;
    logic               cur_valid_reg, cur_valid_next;

    logic [FACT_W-1:0]  factor;
    logic               better;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
            pref_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUTING_MODE:      mode_reg <= cfg_data[MODE_W-1:0];
                REG_PREFERRED_ADDRESS: pref_reg <= cfg_data[ADDR_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        factor = FACT_W'(advert_class) * FACT_W'(received_count);
        case (mode_reg)
            MODE_CLASS:
                better = (advert_class > best_class_reg) ||
                         ((advert_class == best_class_reg) &&
                          (received_count > best_count_reg));
            MODE_FACTOR:
                better = (factor > best_factor_reg) ||
                         ((factor == best_factor_reg) &&
                          (received_count > best_count_reg));
            default:
                better = received_count > best_count_reg;
        endcase
        take = (mode_reg != MODE_OFF) && !no_entries && !locked_reg && !full_reg;
    end

    // state after taking this entry into the scan
    always_comb
    begin
        best_class_upd  = best_class_reg;
        best_count_upd  = best_count_reg;
        best_factor_upd = best_factor_reg;
        cand_addr_upd   = cand_addr_reg;
        cand_idx_upd    = cand_idx_reg;
        counter_upd     = counter_reg;
        locked_upd      = locked_reg;
        full_upd        = full_reg;
        if (take)
        begin
            if ((counter_reg == '0) || better)
            begin
                cand_addr_upd = gateway_address;
                cand_idx_upd  = counter_reg;
            end
            if (advert_class > best_class_reg)
                best_class_upd = advert_class;
            if (received_count > best_count_reg)
                best_count_upd = received_count;
            if (factor > best_factor_reg)
                best_factor_upd = factor;
            // a preferred gateway ends the search
            if ((pref_reg != '0) && (pref_reg == gateway_address))
            begin
                cand_addr_upd = gateway_address;
                cand_idx_upd  = counter_reg;
                locked_upd    = 1'b1;
            end
            if (counter_reg >= LAST_IDX)
                full_upd = 1'b1;
            else
                counter_upd = counter_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_valid = in_fire && (mode_reg != MODE_OFF) && (no_entries || last_entry);
        if (no_entries)
        begin
            res.address  = '0;
            res.index    = '0;
            res.changed  = cur_valid_reg;
            res.no_gw    = 1'b1;
            res.pref_hit = 1'b0;
        end
        else
        begin
            res.address  = cand_addr_upd;
            res.index    = cand_idx_upd;
            res.changed  = !cur_valid_reg || (cur_addr_reg != cand_addr_upd);
            res.no_gw    = 1'b0;
            res.pref_hit = locked_upd;
        end
    end

    always_comb
    begin
        best_class_next  = best_class_reg;
        best_count_next  = best_count_reg;
        best_factor_next = best_factor_reg;
        cand_addr_next   = cand_addr_reg;
        cand_idx_next    = cand_idx_reg;
        counter_next     = counter_reg;
        locked_next      = locked_reg;
        full_next        = full_reg;
        cur_addr_next    = cur_addr_reg;
        cur_valid_next   = cur_valid_reg;
        if (in_fire)
        begin
            if ((mode_reg != MODE_OFF) && !no_entries)
            begin
                best_class_next  = best_class_upd;
                best_count_next  = best_count_upd;
                best_factor_next = best_factor_upd;
                cand_addr_next   = cand_addr_upd;
                cand_idx_next    = cand_idx_upd;
                counter_next     = counter_upd;
                locked_next      = locked_upd;
                full_next        = full_upd;
                if (last_entry)
                begin
                    cur_addr_next  = cand_addr_upd;
                    cur_valid_next = 1'b1;
                end
            end
            if ((mode_reg != MODE_OFF) && no_entries)
            begin
                cur_addr_next  = '0;
                cur_valid_next = 1'b0;
            end
            // end of scan: drop the partial state
            if (no_entries || last_entry)
            begin
                best_class_next  = '0;
                best_count_next  = '0;
                best_factor_next = '0;
                cand_addr_next   = '0;
                cand_idx_next    = '0;
                counter_next     = '0;
                locked_next      = 1'b0;
                full_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_class_reg  <= '0;
            best_count_reg  <= '0;
            best_factor_reg <= '0;
            cand_addr_reg   <= '0;
            cand_idx_reg    <= '0;
            counter_reg     <= '0;
            locked_reg      <= 1'b0;
            full_reg        <= 1'b0;
            cur_addr_reg    <= '0;
            cur_valid_reg   <= 1'b0;
        end
        else
        begin
            best_class_reg  <= best_class_next;
            best_count_reg  <= best_count_next;
            best_factor_reg <= best_factor_next;
            cand_addr_reg   <= cand_addr_next;
            cand_idx_reg    <= cand_idx_next;
            counter_reg     <= counter_next;
            locked_reg      <= locked_next;
            full_reg        <= full_next;
            cur_addr_reg    <= cur_addr_next;
            cur_valid_reg   <= cur_valid_next;
        end
    end

    a_full_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (counter_reg == LAST_IDX))
        else $error("scan full flag set below the entry limit");

    a_cand_behind_counter: assert property (@(posedge clk) disable iff (!rst_n)
        cand_idx_reg <= counter_reg)
        else $error("candidate index ahead of entry counter");

    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (last_entry || no_entries)) |=>
            ((counter_reg == '0) && !locked_reg && !full_reg))
        else $error("scan state not cleared at end of scan");

    a_empty_drops_current: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && no_entries && (mode_reg != MODE_OFF)) |=> !cur_valid_reg)
        else $error("current gateway kept after an empty list");

endmodule

// ===== rtl/core/gws_out_reg.sv =====
// ----------------------------------------------------------------------------
// gws_out_reg
// Result register between the scan logic and the output channel; holds a
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module gws_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  gws_pkg::gws_result_t res,
    output logic                 up_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gws_pkg::gws_result_t out_res
);
    import gws_pkg::*;

    logic        valid_reg, valid_next;
    gws_result_t data_reg;

    // the register frees up in the same cycle that its result is taken
    assign up_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
            valid_next = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && load)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |-> !up_ready)
        else $error("input open while a result is stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (up_ready && load) |=> valid_reg)
        else $error("loaded result not presented");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (up_ready && !load) |=> !valid_reg)
        else $error("result presented without a load");

endmodule

// ===== rtl/core/gateway_selection.sv =====
// ----------------------------------------------------------------------------
// gateway_selection
// Picks the best gateway from a scan of the known gateway list.
// ----------------------------------------------------------------------------
// Feed one gateway entry per input transaction (in_valid/in_ready); mark the
// final entry with last_entry, or send a single transaction with no_entries
// set when the list is empty. A scan yields one result transaction on
// out_valid/out_ready, raised on the cycle after the last entry is taken;
// other entries produce none, and routing mode off produces none at all.
// Throughput is one entry per cycle: each entry passes one 4x16 multiply and
// a few compares against the running maxima; the scan result lands in the
// result register. While a result waits in that register and out_ready is
// low, in_ready stays low; it rises again in the cycle the result is taken.
// routing_mode and preferred_address are written through cfg_we, cfg_index
// and cfg_data, by the user only between transactions (the block does not
// enforce it). Reset clears the scan, the current gateway, both registers
// and any pending result. Entries past MAX_GATEWAYS in one scan are ignored.
// ----------------------------------------------------------------------------
module gateway_selection #(
    parameter int MAX_GATEWAYS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gws_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gws_pkg::ADDR_W-1:0]    gateway_address,
    input  logic [gws_pkg::CLASS_W-1:0]   advert_class,
    input  logic [gws_pkg::COUNT_W-1:0]   received_count,
    input  logic                          no_entries,
    input  logic                          last_entry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gws_pkg::ADDR_W-1:0]    chosen_address,
    output logic [gws_pkg::IDX_W-1:0]     chosen_index,
    output logic                          route_changed,
    output logic                          no_gateway,
    output logic                          preferred_hit
);
    import gws_pkg::*;

    logic        in_fire;
    logic        res_valid;
    gws_result_t res;
    gws_result_t out_res;

    assign in_fire = in_valid && in_ready;

    gws_scan #(
        .MAX_GATEWAYS (MAX_GATEWAYS)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_fire         (in_fire),
        .gateway_address (gateway_address),
        .advert_class    (advert_class),
        .received_count  (received_count),
        .no_entries      (no_entries),
        .last_entry      (last_entry),
        .res_valid       (res_valid),
        .res             (res)
    );

    gws_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .up_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign chosen_address = out_res.address;
    assign chosen_index   = out_res.index;
    assign route_changed  = out_res.changed;
    assign no_gateway     = out_res.no_gw;
    assign preferred_hit  = out_res.pref_hit;

endmodule

// ===== dv/gateway_selection_tb.sv =====
// ----------------------------------------------------------------------------
// gateway_selection_tb
// Self-checking bench for the gateway selection block. A driver offers
// queued gateway entries with random gaps, a monitor takes results with
// random stalls, and an in-bench predictor of the scan works out every
// result as entries are accepted. Phases switch routing mode and preferred
// address while the block is idle; one phase holds the result side off long
// enough to stall the input, and some scans wait for all results first.
// ----------------------------------------------------------------------------
module gateway_selection_tb;
    import gws_pkg::*;

    localparam int MAX_GW      = 256;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic [CLASS_W-1:0] cls;
        logic [COUNT_W-1:0] cnt;
        logic               empty;
        logic               last;
        int unsigned        pre_gap;
        bit                 drain_first;
    } gw_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [ADDR_W-1:0] gateway_address = '0;
    logic [CLASS_W-1:0] advert_class = '0;
    logic [COUNT_W-1:0] received_count = '0;
    logic no_entries = 1'b0;
    logic last_entry = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ADDR_W-1:0] chosen_address;
    logic [IDX_W-1:0] chosen_index;
    logic route_changed;
    logic no_gateway;
    logic preferred_hit;

    gateway_selection #(
        .MAX_GATEWAYS(MAX_GW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .gateway_address(gateway_address),
        .advert_class(advert_class),
        .received_count(received_count),
        .no_entries(no_entries),
        .last_entry(last_entry),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .chosen_address(chosen_address),
        .chosen_index(chosen_index),
        .route_changed(route_changed),
        .no_gateway(no_gateway),
        .preferred_hit(preferred_hit)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of configuration and scan state
    logic [MODE_W-1:0]  sel_mode = MODE_OFF;
    logic [ADDR_W-1:0]  sel_pref = '0;
    logic [CLASS_W-1:0] best_cls;
    logic [COUNT_W-1:0] best_cnt;
    logic [FACT_W-1:0]  best_fac;
    logic [ADDR_W-1:0]  cand_addr;
    logic [IDX_W-1:0]   cand_idx;
    logic [IDX_W-1:0]   scan_pos;
    logic               locked;
    logic               full;
    logic [ADDR_W-1:0]  cur_addr = '0;
    logic               cur_valid = 1'b0;

    gw_entry_t   pending_entries[$];
    gws_result_t expected_choices[$];
    gw_entry_t   offered;
    int unsigned gap_count = 0;
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    logic        hold_kick = 1'b0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned entries_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned pref_results = 0;
    int unsigned empty_results = 0;
    int unsigned phases_run = 0;

    task automatic clear_scan();
        best_cls = '0;
        best_cnt = '0;
        best_fac = '0;
        cand_addr = '0;
        cand_idx = '0;
        scan_pos = '0;
        locked = 1'b0;
        full = 1'b0;
    endtask

    initial clear_scan();

    task automatic take_gateway(input gw_entry_t e);
        logic [FACT_W-1:0] fac;
        logic better;
        fac = FACT_W'(e.cls) * FACT_W'(e.cnt);
        case (sel_mode)
            MODE_CLASS:  better = (e.cls > best_cls) || (e.cls == best_cls && e.cnt > best_cnt);
            MODE_FACTOR: better = (fac > best_fac) || (fac == best_fac && e.cnt > best_cnt);
            default:     better = e.cnt > best_cnt;
        endcase
        // the first entry of a scan is always the candidate
        if (scan_pos == '0 || better)
        begin
            cand_addr = e.addr;
            cand_idx = scan_pos;
        end
        if (e.cls > best_cls) best_cls = e.cls;
        if (e.cnt > best_cnt) best_cnt = e.cnt;
        if (fac > best_fac) best_fac = fac;
        if (sel_pref != '0 && sel_pref == e.addr)
        begin
            cand_addr = e.addr;
            cand_idx = scan_pos;
            locked = 1'b1;
        end
        if (int'(scan_pos) >= MAX_GW - 1)
            full = 1'b1;
        else
            scan_pos = scan_pos + 1'b1;
    endtask

    task automatic select_gateway(input gw_entry_t e);
        gws_result_t r;
        if (sel_mode == MODE_OFF)
        begin
            if (e.empty || e.last)
                clear_scan();
        end
        else if (e.empty)
        begin
            r.address = '0;
            r.index = '0;
            r.changed = cur_valid;
            r.no_gw = 1'b1;
            r.pref_hit = 1'b0;
            expected_choices.push_back(r);
            cur_addr = '0;
            cur_valid = 1'b0;
            clear_scan();
        end
        else
        begin
            if (!locked && !full)
                take_gateway(e);
            if (e.last)
            begin
                r.address = cand_addr;
                r.index = cand_idx;
                r.changed = !cur_valid || cur_addr != cand_addr;
                r.no_gw = 1'b0;
                r.pref_hit = locked;
                expected_choices.push_back(r);
                cur_addr = cand_addr;
                cur_valid = 1'b1;
                clear_scan();
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // driver: hold valid and payload until the transaction is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_count = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                select_gateway(offered);
                entries_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_entries.size() == 0 ||
                    (pending_entries[0].drain_first && expected_choices.size() != 0))
                    in_valid <= 1'b0;
                else if (gap_count < pending_entries[0].pre_gap)
                begin
                    gap_count++;
                    in_valid <= 1'b0;
                end
                else
                begin
                    offered = pending_entries.pop_front();
                    gap_count = 0;
                    in_valid <= 1'b1;
                    gateway_address <= offered.addr;
                    advert_class <= offered.cls;
                    received_count <= offered.cnt;
                    no_entries <= offered.empty;
                    last_entry <= offered.last;
                end
            end
        end
    end

    // monitor: check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        gws_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_choices.size() == 0)
                begin
                    $error("result with no expectation pending, address %0h", chosen_address);
                    mismatches++;
                end
                else
                begin
                    want = expected_choices.pop_front();
                    compare_field("chosen_address", want.address, chosen_address);
                    compare_field("chosen_index", 32'(want.index), 32'(chosen_index));
                    compare_field("route_changed", 32'(want.changed), 32'(route_changed));
                    compare_field("no_gateway", 32'(want.no_gw), 32'(no_gateway));
                    compare_field("preferred_hit", 32'(want.pref_hit), 32'(preferred_hit));
                    results_checked++;
                    if (want.pref_hit) pref_results++;
                    if (want.no_gw) empty_results++;
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 10) : 0;
            end
            else if (rx_wait > 0)
                rx_wait--;
            out_ready <= (rx_wait == 0) && (hold_left == 0) && !hold_kick;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, expected_choices.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROUTING_MODE)
            sel_mode = val[MODE_W-1:0];
        else
            sel_pref = val;
    endtask

    task automatic push_entry(input logic [ADDR_W-1:0] addr, input logic [CLASS_W-1:0] cls,
                              input logic [COUNT_W-1:0] cnt, input logic empty,
                              input logic last, input bit drain);
        gw_entry_t e;
        e.addr = addr;
        e.cls = cls;
        e.cnt = cnt;
        e.empty = empty;
        e.last = last;
        e.pre_gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        e.drain_first = drain;
        pending_entries.push_back(e);
    endtask

    // wait for the block to go idle before touching its registers; sample
    // on the falling edge so that the driver's updates have settled
    task automatic drain_results();
        do
            @(negedge clk);
        while (pending_entries.size() != 0 || in_valid || out_valid ||
               expected_choices.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    logic [ADDR_W-1:0] addr_pool [8];
    logic [MODE_W-1:0] mode_plan [4] = '{MODE_CLASS, MODE_FACTOR, MODE_COUNT, MODE_OFF};

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 9) < 6)
            return addr_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return COUNT_W'($urandom_range(0, 65535));
        if (r < 8) return COUNT_W'($urandom_range(0, 7));
        return r[0] ? 16'hFFFF : 16'h0000;
    endfunction

    initial
    begin
        int quota;
        int pushed;
        int len;
        int r;
        bit broken;

        addr_pool[0] = '0;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            addr_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: class mode, no preference
        write_reg(REG_ROUTING_MODE, CFG_W'(MODE_CLASS));
        write_reg(REG_PREFERRED_ADDRESS, '0);
        // empty list with no current gateway; last mark is ignored
        push_entry(32'h1234_5678, 4'hF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        push_entry(32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0000_0000, 4'h0, 16'h0000, 1'b0, 1'b1, 1'b0);
        // nothing beats zero: first entry stays chosen, then same gateway again
        push_entry(32'h0000_0000, 4'h0, 16'h0000, 1'b0, 1'b1, 1'b0);
        push_entry(32'h0000_0000, 4'h0, 16'h0000, 1'b0, 1'b1, 1'b0);
        // class tie broken by count
        push_entry(32'h0A00_0001, 4'h5, 16'd10, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0A00_0002, 4'h5, 16'd20, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0A00_0003, 4'h4, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        // empty list drops the current gateway
        push_entry(32'h0000_0000, 4'h0, 16'h0000, 1'b1, 1'b0, 1'b0);
        drain_results();

        write_reg(REG_ROUTING_MODE, CFG_W'(MODE_FACTOR));
        push_entry(32'h0A00_0011, 4'h2, 16'd100, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0A00_0012, 4'h4, 16'd50, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0A00_0013, 4'h1, 16'd200, 1'b0, 1'b1, 1'b0);
        push_entry(32'h0A00_0014, 4'hF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0A00_0015, 4'hF, 16'hFFFE, 1'b0, 1'b1, 1'b0);
        drain_results();

        // preferred hit ends the search; later better entries are ignored
        write_reg(REG_ROUTING_MODE, CFG_W'(MODE_COUNT));
        write_reg(REG_PREFERRED_ADDRESS, 32'h0000_00A5);
        push_entry(32'h0A00_0021, 4'h0, 16'd10, 1'b0, 1'b0, 1'b1);
        push_entry(32'h0000_00A5, 4'h0, 16'd1, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0A00_0023, 4'hF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        drain_results();

        // over-long scan: entries past the table size are ignored, last still ends it
        write_reg(REG_PREFERRED_ADDRESS, 32'hFFFF_FFFF);
        for (int i = 0; i < MAX_GW + 44; i++)
        begin
            if (i < MAX_GW)
                push_entry(32'h0B00_0000 + i, i[3:0], i[15:0], 1'b0, 1'b0, 1'b0);
            else
                push_entry(32'hFFFF_FFFF, 4'hF, 16'hFFFF, 1'b0, i == MAX_GW + 43, 1'b0);
        end
        drain_results();

        // mode off: a last mark still clears a partial scan
        write_reg(REG_ROUTING_MODE, CFG_W'(MODE_CLASS));
        push_entry(32'h0C00_0001, 4'hF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        drain_results();
        write_reg(REG_ROUTING_MODE, CFG_W'(MODE_OFF));
        push_entry(32'h0C00_0002, 4'h3, 16'd3, 1'b0, 1'b0, 1'b0);
        push_entry(32'h0C00_0003, 4'h3, 16'd3, 1'b0, 1'b1, 1'b0);
        push_entry(32'h0C00_0004, 4'h3, 16'd3, 1'b1, 1'b0, 1'b0);
        drain_results();
        write_reg(REG_ROUTING_MODE, CFG_W'(MODE_CLASS));
        push_entry(32'h0C00_0005, 4'h0, 16'h0000, 1'b0, 1'b1, 1'b0);
        drain_results();
        phases_run = 5;

        // random phases
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_ROUTING_MODE, CFG_W'(mode_plan[ph % 4]));
            write_reg(REG_PREFERRED_ADDRESS, (ph % 3 == 0) ? '0 : addr_pool[$urandom_range(1, 7)]);
            tx_idle_on = !(ph == 2 || ph == 5);
            rx_idle_on = (ph != 5);
            if (ph == 2)
            begin
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            quota = (mode_plan[ph % 4] == MODE_OFF) ? 15 : 50;
            pushed = 0;
            while (pushed < quota)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    push_entry($urandom, CLASS_W'($urandom_range(0, 15)), pick_count(), 1'b1,
                               1'($urandom_range(0, 1)), 1'b0);
                    pushed++;
                end
                else
                begin
                    len = (r < 90) ? $urandom_range(1, 6) : $urandom_range(7, 24);
                    broken = (r >= 95);
                    for (int i = 0; i < len; i++)
                        push_entry(pick_addr(), CLASS_W'($urandom_range(0, 15)), pick_count(),
                                   1'b0, (i == len - 1) && !broken,
                                   (i == 0) && ($urandom_range(0, 99) < 3));
                    pushed += len;
                    // interrupted scan: cut short by an empty list
                    if (broken)
                    begin
                        push_entry(pick_addr(), CLASS_W'($urandom_range(0, 15)), pick_count(),
                                   1'b1, 1'b0, 1'b0);
                        pushed++;
                    end
                end
            end
            drain_results();
            phases_run++;
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        drain_results();
        repeat (10) @(posedge clk);
        $display("covered %0d phases, %0d entries accepted, %0d results checked",
                 phases_run, entries_accepted, results_checked);
        $display("  of which %0d preferred hits and %0d empty lists, %0d mismatches",
                 pref_results, empty_results, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gws_pkg.sv
rtl/core/gws_scan.sv
rtl/core/gws_out_reg.sv
rtl/core/gateway_selection.sv
dv/gateway_selection_tb.sv
